>>> rtl/core/running_mean_stdev_core_macros.svh
// Assertion macros used by the running_mean_stdev_core port checker.
`ifndef RUNNING_MEAN_STDEV_CORE_MACROS_SVH
`define RUNNING_MEAN_STDEV_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define RMSD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("running_mean_stdev_core check failed");

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define RMSD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("running_mean_stdev_core check failed");

`endif

>>> rtl/core/rmsd_pkg.sv
// Package: sizes, snapshot and divider status types for the running mean/stdev core.
package rmsd_pkg;

  localparam int unsigned MAX_SAMPLES = 1048576;
  localparam int unsigned FRAC_BITS   = 16;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned LG_MAX    = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W     = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W     = LG_MAX + SAMPLE_W;
  localparam int unsigned SQ_W      = LG_MAX + 2 * SAMPLE_W - 1;
  localparam int unsigned MAG_W     = SUM_W;
  localparam int unsigned NUM_W     = MAG_W + FRAC_BITS;
  localparam int unsigned PRD_W     = CNT_W + SQ_W;
  localparam int unsigned X_W       = PRD_W + 2 * FRAC_BITS;
  localparam int unsigned XP_W      = X_W + (X_W % 2);
  localparam int unsigned ROOT_W    = XP_W / 2;
  localparam int unsigned DIV_W     = (NUM_W > ROOT_W) ? NUM_W : ROOT_W;
  localparam int unsigned MUL_STEPS = (CNT_W > MAG_W) ? CNT_W : MAG_W;
  localparam int unsigned MAX_STEPS = (MUL_STEPS > ROOT_W) ? MUL_STEPS : ROOT_W;
  localparam int unsigned STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int unsigned QD        = 2;

  // Accumulator snapshot handed from the front to the back.
  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sq;
    logic                    ovf;
  } snap_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_nz;
  } div_stat_t;

endpackage

>>> rtl/core/rmsd_front.sv
// Front end: accept samples, classify start/accumulate/frozen, keep the exact sums.
module rmsd_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic                             full,
  input  logic signed [rmsd_pkg::SAMPLE_W-1:0] sample,
  input  logic                             start_req,
  output logic                             wr,
  output rmsd_pkg::snap_t                  snap
);

  rmsd_pkg::snap_t acc;
  rmsd_pkg::snap_t base;
  logic signed [2*rmsd_pkg::SAMPLE_W-1:0] sq_prod;

  assign wr = push & ~full;
  assign sq_prod = sample * sample;

  always_comb begin
    base = start_req ? '0 : acc;
    snap = base;
    if (base.cnt >= rmsd_pkg::CNT_W'(rmsd_pkg::MAX_SAMPLES)) begin
      snap.ovf = 1'b1;
    end else begin
      snap.cnt = base.cnt + rmsd_pkg::CNT_W'(1);
      snap.sum = base.sum + rmsd_pkg::SUM_W'(sample);
      snap.sq  = base.sq + rmsd_pkg::SQ_W'(sq_prod[2*rmsd_pkg::SAMPLE_W-2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (wr) begin
      acc <= snap;
    end
  end

endmodule

>>> rtl/core/rmsd_fifo.sv
// Two-entry queue of accumulator snapshots between front and back.
module rmsd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  rmsd_pkg::snap_t din,
  output logic            full,
  input  logic            rd,
  output logic            avail,
  output rmsd_pkg::snap_t dout
);

  localparam int unsigned PTR_W = $clog2(rmsd_pkg::QD);
  localparam int unsigned FILL_W = $clog2(rmsd_pkg::QD + 1);

  rmsd_pkg::snap_t   mem [rmsd_pkg::QD];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full  = (fill == FILL_W'(rmsd_pkg::QD));
  assign avail = (fill != '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        fill <= fill + FILL_W'(1);
      end else if (rd && !wr) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/rmsd_div.sv
// Restoring divider, one quotient bit per cycle, divisor is the sample count.
module rmsd_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rmsd_pkg::DIV_W-1:0]   num,
  input  logic [rmsd_pkg::CNT_W-1:0]   den,
  output rmsd_pkg::div_stat_t          stat,
  output logic [rmsd_pkg::DIV_W-1:0]   quo
);

  localparam int unsigned CW = $clog2(rmsd_pkg::DIV_W + 1);

  logic [rmsd_pkg::CNT_W-1:0] rem;
  logic [rmsd_pkg::CNT_W-1:0] dvs;
  logic [CW-1:0]              cnt;
  logic                       busy;
  logic                       done;
  logic [rmsd_pkg::CNT_W:0]   trial;
  logic [rmsd_pkg::CNT_W:0]   diff;
  logic                       ge;

  assign trial = {rem, quo[rmsd_pkg::DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};
  assign stat  = '{busy: busy, done: done, rem_nz: (rem != '0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      dvs <= den;
      rem <= '0;
      cnt <= CW'(rmsd_pkg::DIV_W);
    end else if (busy) begin
      // Shift in one quotient bit, keep the partial remainder below the divisor.
      rem <= ge ? diff[rmsd_pkg::CNT_W-1:0] : trial[rmsd_pkg::CNT_W-1:0];
      quo <= {quo[rmsd_pkg::DIV_W-2:0], ge};
      cnt <= cnt - CW'(1);
    end
  end

endmodule

>>> rtl/core/rmsd_back.sv
// Back end: serial products, digit-by-digit square root and divisions per snapshot.
module rmsd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_avail,
  input  rmsd_pkg::snap_t            q_snap,
  output logic                       q_rd,
  input  logic                       pop,
  output logic                       empty,
  output logic [rmsd_pkg::OUT_W-1:0] mean_out,
  output logic [rmsd_pkg::OUT_W-1:0] stdev_out,
  output logic                       overflow
);

  localparam int unsigned REM_W = rmsd_pkg::ROOT_W + 2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ROOT = 5'b00100,
    S_DIVR = 5'b01000,
    S_DONE = 5'b10000
  } bstate_t;

  bstate_t                        state;
  logic [rmsd_pkg::CNT_W-1:0]     n;
  logic                           neg;
  logic                           ovf;
  logic [rmsd_pkg::CNT_W-1:0]     n_sh;
  logic [rmsd_pkg::MAG_W-1:0]     s_bits;
  logic [rmsd_pkg::PRD_W-1:0]     q_sh;
  logic [rmsd_pkg::PRD_W-1:0]     m_sh;
  logic [rmsd_pkg::PRD_W-1:0]     nq;
  logic [rmsd_pkg::PRD_W-1:0]     ss;
  logic [rmsd_pkg::STEP_W-1:0]    step;
  logic [rmsd_pkg::XP_W-1:0]      x;
  logic [rmsd_pkg::ROOT_W-1:0]    root;
  logic [REM_W-1:0]               rem;
  logic [rmsd_pkg::OUT_W-1:0]     mean_w;
  logic                           div_root;
  logic                           out_valid;

  logic [rmsd_pkg::MAG_W-1:0]     mag_in;
  logic                           div_start;
  logic [rmsd_pkg::DIV_W-1:0]     div_num;
  logic [rmsd_pkg::CNT_W-1:0]     div_den;
  rmsd_pkg::div_stat_t            dstat;
  logic [rmsd_pkg::DIV_W-1:0]     quo;
  logic [REM_W+1:0]               t;
  logic [REM_W+1:0]               trial;
  logic                           t_ge;
  logic [rmsd_pkg::PRD_W-1:0]     dvar;
  logic [rmsd_pkg::OUT_W-1:0]     q32;

  assign empty  = ~out_valid;
  assign mag_in = q_snap.sum[rmsd_pkg::SUM_W-1] ? rmsd_pkg::MAG_W'(-q_snap.sum)
                                                : rmsd_pkg::MAG_W'(q_snap.sum);
  assign q_rd   = (state == S_IDLE) && q_avail;
  assign dvar   = (ss > nq) ? '0 : (nq - ss);
  assign t      = {rem, x[rmsd_pkg::XP_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root, 2'b01});
  assign t_ge   = t >= trial;
  assign q32    = quo[rmsd_pkg::OUT_W-1:0];

  // Divisor: the incoming count when a snapshot is taken, the held count otherwise.
  assign div_den = q_rd ? q_snap.cnt : n;

  always_comb begin
    div_start = 1'b0;
    div_num   = rmsd_pkg::DIV_W'(mag_in) << rmsd_pkg::FRAC_BITS;
    if (q_rd) begin
      div_start = 1'b1;
    end else if (state == S_ROOT && step == '0 && !dstat.busy) begin
      div_start = 1'b1;
      div_num   = rmsd_pkg::DIV_W'(root);
    end
  end

  rmsd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (dstat),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Load a finished result when the output is free or being drained.
      if (state == S_DONE && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_avail) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (step == '0) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (step == '0 && !dstat.busy) begin
            state <= S_DIVR;
          end
        end
        S_DIVR: begin
          if (dstat.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || pop) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    // Mean quotient arrives first; floor a negative mean by rounding its magnitude up.
    if (dstat.done && !div_root) begin
      mean_w <= neg ? (-(q32 + rmsd_pkg::OUT_W'(dstat.rem_nz))) : q32;
    end
    if (div_start) begin
      div_root <= !q_rd;
    end
    case (state)
      S_IDLE: begin
        if (q_avail) begin
          n      <= q_snap.cnt;
          neg    <= q_snap.sum[rmsd_pkg::SUM_W-1];
          ovf    <= q_snap.ovf;
          n_sh   <= q_snap.cnt;
          s_bits <= mag_in;
          q_sh   <= rmsd_pkg::PRD_W'(q_snap.sq);
          m_sh   <= rmsd_pkg::PRD_W'(mag_in);
          nq     <= '0;
          ss     <= '0;
          step   <= rmsd_pkg::STEP_W'(rmsd_pkg::MUL_STEPS);
        end
      end
      S_MUL: begin
        if (step != '0) begin
          if (n_sh[0]) begin
            nq <= nq + q_sh;
          end
          if (s_bits[0]) begin
            ss <= ss + m_sh;
          end
          n_sh   <= n_sh >> 1;
          s_bits <= s_bits >> 1;
          q_sh   <= q_sh << 1;
          m_sh   <= m_sh << 1;
          step   <= step - rmsd_pkg::STEP_W'(1);
        end else begin
          x    <= rmsd_pkg::XP_W'(dvar) << (2 * rmsd_pkg::FRAC_BITS);
          root <= '0;
          rem  <= '0;
          step <= rmsd_pkg::STEP_W'(rmsd_pkg::ROOT_W);
        end
      end
      S_ROOT: begin
        if (step != '0) begin
          rem  <= t_ge ? REM_W'(t - trial) : REM_W'(t);
          root <= {root[rmsd_pkg::ROOT_W-2:0], t_ge};
          x    <= x << 2;
          step <= step - rmsd_pkg::STEP_W'(1);
        end
      end
      S_DONE: begin
        // The root quotient holds in the idle divider until the output takes it.
        if (!out_valid || pop) begin
          mean_out  <= mean_w;
          stdev_out <= q32;
          overflow  <= ovf;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/running_mean_stdev_core.sv
// Top level: running mean and population standard deviation of audio samples.
//
// Input channel: drive sample and start_req with push; the sample is taken on a
// rising edge where push is high and full is low. start_req clears the count,
// sum and sum of squares so that this sample opens a new sequence.
// Result channel: while empty is low, mean_out, stdev_out and overflow show the
// oldest result; it is consumed on an edge where pop is high and empty is low.
// One result per sample, in order. Both statistics carry 16 fraction bits and
// are floored. After MAX_SAMPLES samples further samples are dropped, the
// statistics freeze and overflow stays high until the next start_req.
// Per result the back end runs 36 serial product steps, 52 square-root steps and
// two 52-step divisions, the first alongside the products and root; the single
// back-end sequencer finishes one snapshot before it takes the next.
// The front updates the sums at once and parks a snapshot in a two-entry queue,
// so two more samples are taken while the back end works.
// Reset (rst, synchronous) clears the sums, empties the queue and drops any
// pending result. A stalled receiver holds the result; the back end then waits
// with the next finished result and full rises once the queue fills.
module running_mean_stdev_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [rmsd_pkg::SAMPLE_W-1:0] sample,
  input  logic                              start_req,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [rmsd_pkg::OUT_W-1:0] mean_out,
  output logic [rmsd_pkg::OUT_W-1:0]        stdev_out,
  output logic                              overflow
);

  logic            wr;
  rmsd_pkg::snap_t snap_in;
  logic            q_avail;
  logic            q_rd;
  rmsd_pkg::snap_t snap_out;
  logic [rmsd_pkg::OUT_W-1:0] mean_raw;

  // Accumulate and classify each transaction as it arrives.
  rmsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .sample    (sample),
    .start_req (start_req),
    .wr        (wr),
    .snap      (snap_in)
  );

  // Hold snapshots until the back end is free.
  rmsd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .din   (snap_in),
    .full  (full),
    .rd    (q_rd),
    .avail (q_avail),
    .dout  (snap_out)
  );

  // Turn each snapshot into mean and standard deviation, hold in the output stage.
  rmsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_avail   (q_avail),
    .q_snap    (snap_out),
    .q_rd      (q_rd),
    .pop       (pop),
    .empty     (empty),
    .mean_out  (mean_raw),
    .stdev_out (stdev_out),
    .overflow  (overflow)
  );

  assign mean_out = $signed(mean_raw);

endmodule

>>> rtl/core/rmsd_checker.sv
// Port checker for running_mean_stdev_core and its bind.
`include "running_mean_stdev_core_macros.svh"

module rmsd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              push,
  input logic                              full,
  input logic                              empty,
  input logic                              pop,
  input logic signed [rmsd_pkg::OUT_W-1:0] mean_out,
  input logic [rmsd_pkg::OUT_W-1:0]        stdev_out,
  input logic                              overflow
);

  `RMSD_ASSERT_IMP(a_empty_after_reset, $past(rst), empty)
  `RMSD_ASSERT_IMP(a_full_needs_push, $rose(full), $past(push) && !$past(full))
  `RMSD_ASSERT_IMP(a_stdev_range, !empty, stdev_out <= 32'h8000_0000)
  `RMSD_ASSERT_IMP(a_mean_range, !empty, mean_out <= 32'sh7FFF_0000)
  `RMSD_ASSERT_NXT(a_result_holds, !empty && !pop,
                   !empty && $stable(mean_out) && $stable(stdev_out) && $stable(overflow))

endmodule

bind running_mean_stdev_core rmsd_checker u_rmsd_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .mean_out  (mean_out),
  .stdev_out (stdev_out),
  .overflow  (overflow)
);
